### design/tshs_pkg.sv
// Package for the timestamp history store.
// Holds the item types, function and status codes and default sizes.
// No dependencies; tshs_seq, the top level and both dv files import it.
package tshs_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned DEVICES_DEF = 8;
  localparam int unsigned DEPTH_DEF   = 32;

  // Largest number of points one newest-k request returns.
  localparam int unsigned OUT_MAX = 32;

  // Field widths fixed by the item format.
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned GPU_IDX_W = 3;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned K_W       = 6;
  localparam int unsigned STATUS_W  = 2;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEFORE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_AFTER  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NEWEST = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;

  // One request item.
  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [GPU_IDX_W-1:0] gpu_index;
    logic [TIME_W-1:0]    gpu_time;
    logic [TIME_W-1:0]    host_time;
    logic [K_W-1:0]       count_k;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   found_gpu_time;
    logic [TIME_W-1:0]   found_host_time;
    logic                last;
  } out_item_t;

endpackage

### design/tshs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// The read data holds its value while no read is issued.
// Depends on nothing.
module tshs_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned WORDS = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(WORDS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(WORDS)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [WORDS];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tshs_seq.sv
// Request sequencer of the timestamp history store: per-device ring state,
// the shared slot adder and comparator, and the binary search loop.
// Depends on tshs_pkg; drives the point RAM through its ports.
module tshs_seq import tshs_pkg::*; #(
  parameter int unsigned DEVICES = DEVICES_DEF,
  parameter int unsigned DEPTH   = DEPTH_DEF,
  localparam int unsigned DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1,
  localparam int unsigned SLOT_W = $clog2(DEPTH),
  localparam int unsigned ADDR_W = DEV_W + SLOT_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  input  logic [CFG_W-1:0]    max_entries_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output out_item_t           res_data_o,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [2*TIME_W-1:0] ram_wdata_o,
  output logic                ram_re_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  input  logic [2*TIME_W-1:0] ram_rdata_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = ((DEV_W > GPU_IDX_W) ? DEV_W : GPU_IDX_W) + 1;
  localparam int unsigned CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned N_W   = $clog2(OUT_MAX + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ACT,
    ST_SRCH,
    ST_SCMP,
    ST_PICK,
    ST_CHK,
    ST_FETCH,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [FUNC_W-1:0]      func_q;
  logic [DEV_W-1:0]       dev_q;
  logic                   dev_ok_q;
  logic [TIME_W-1:0]      target_q;
  logic [TIME_W-1:0]      host_q;
  logic [K_W-1:0]         k_q;
  logic [SLOT_W-1:0]      head_q [DEVICES];
  logic [CNT_W-1:0]       cnt_q [DEVICES];
  logic [DEVICES-1:0]     present_q;
  logic [SLOT_W-1:0]      cur_head_q;
  logic [CNT_W-1:0]       cur_cnt_q;
  logic                   cur_present_q;
  logic [CNT_W-1:0]       first_q;
  logic [CNT_W-1:0]       len_q;
  logic [N_W-1:0]         n_q;
  logic [N_W-1:0]         idx_q;
  logic [STATUS_W-1:0]    status_q;
  logic                   last_q;
  logic                   use_ram_q;

  logic [IDX_W-1:0]       gpu_ext;
  logic                   gpu_ok;
  logic [CNT_W-1:0]       half;
  logic [CNT_W-1:0]       mid;
  logic [CNT_W-1:0]       pos;
  logic [SUM_W-1:0]       slot_sum;
  logic [SLOT_W-1:0]      slot;
  logic [CMP_W-1:0]       limit;
  logic                   over_limit;
  logic [CMP_W-1:0]       k_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       min_kc;
  logic [N_W-1:0]         n_new;
  logic [CMP_W-1:0]       fetch_pos;
  logic [TIME_W-1:0]      ram_gt;
  logic                   ram_lt;
  logic                   ram_eq;
  logic                   p_in_range;
  logic                   p_is_zero;
  logic [SLOT_W-1:0]      head_next;

  // Device index check against the configured device count.
  assign gpu_ext = IDX_W'(in_data_i.gpu_index);
  assign gpu_ok  = (gpu_ext < IDX_W'(DEVICES));

  // Search window split and end-of-history tests.
  assign half       = len_q >> 1;
  assign mid        = first_q + half;
  assign p_in_range = (first_q < cur_cnt_q);
  assign p_is_zero  = (first_q == '0);

  // History limit: zero or anything above the ring size means the full ring.
  always_comb begin
    if (max_entries_i == '0 || CMP_W'(max_entries_i) > CMP_W'(DEPTH)) begin
      limit = CMP_W'(DEPTH);
    end else begin
      limit = CMP_W'(max_entries_i);
    end
  end
  assign over_limit = (CMP_W'(cur_cnt_q) + CMP_W'(1)) > limit;
  assign head_next  = (cur_head_q == SLOT_W'(DEPTH - 1)) ? '0 : cur_head_q + SLOT_W'(1);

  // Number of newest points returned, capped by the count and the output limit.
  assign k_ext   = CMP_W'(k_q);
  assign cnt_ext = CMP_W'(cur_cnt_q);
  assign min_kc  = (k_ext < cnt_ext) ? k_ext : cnt_ext;
  assign n_new   = (min_kc > CMP_W'(OUT_MAX)) ? N_W'(OUT_MAX) : N_W'(min_kc);
  assign fetch_pos = cnt_ext - CMP_W'(n_q) + CMP_W'(idx_q);

  // Logical position fed to the shared slot adder in each state.
  always_comb begin
    case (state_q)
      ST_SRCH:  pos = mid;
      ST_PICK: begin
        if (func_q == FUNC_AFTER || p_in_range) begin
          pos = first_q;
        end else begin
          pos = first_q - CNT_W'(1);
        end
      end
      ST_CHK:   pos = first_q - CNT_W'(1);
      ST_FETCH: pos = CNT_W'(fetch_pos);
      default:  pos = cur_cnt_q;
    endcase
  end

  // Shared slot unit: ring head plus logical position, wrapped once.
  assign slot_sum = SUM_W'(cur_head_q) + SUM_W'(pos);
  assign slot     = (slot_sum >= SUM_W'(DEPTH)) ? SLOT_W'(slot_sum - SUM_W'(DEPTH))
                                                : SLOT_W'(slot_sum);

  // Shared comparator on the device time read back from the RAM.
  assign ram_gt = ram_rdata_i[2*TIME_W-1:TIME_W];
  assign ram_lt = (ram_gt < target_q);
  assign ram_eq = (ram_gt == target_q);

  // RAM port control.
  assign ram_raddr_o = {dev_q, slot};
  assign ram_waddr_o = {dev_q, slot};
  assign ram_wdata_o = {target_q, host_q};
  assign ram_we_o    = (state_q == ST_ACT) && dev_ok_q && (func_q == FUNC_WRITE);
  always_comb begin
    case (state_q)
      ST_SRCH:  ram_re_o = (len_q != '0);
      ST_PICK:  ram_re_o = (func_q == FUNC_AFTER) ? p_in_range : (p_in_range || !p_is_zero);
      ST_CHK:   ram_re_o = !ram_eq && !p_is_zero;
      ST_FETCH: ram_re_o = 1'b1;
      default:  ram_re_o = 1'b0;
    endcase
  end

  // Handshake and result payload.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_EMIT);
  always_comb begin
    res_data_o.status = status_q;
    res_data_o.last   = last_q;
    if (use_ram_q) begin
      res_data_o.found_gpu_time  = ram_rdata_i[2*TIME_W-1:TIME_W];
      res_data_o.found_host_time = ram_rdata_i[TIME_W-1:0];
    end else begin
      res_data_o.found_gpu_time  = '0;
      res_data_o.found_host_time = '0;
    end
  end

  // Sequencer, ring state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      present_q <= '0;
      for (int i = 0; i < int'(DEVICES); i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            func_q   <= in_data_i.func;
            target_q <= in_data_i.gpu_time;
            host_q   <= in_data_i.host_time;
            k_q      <= in_data_i.count_k;
            dev_ok_q <= gpu_ok;
            dev_q    <= gpu_ok ? gpu_ext[DEV_W-1:0] : '0;
            state_q  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cur_head_q    <= head_q[dev_q];
          cur_cnt_q     <= cnt_q[dev_q];
          cur_present_q <= present_q[dev_q];
          state_q       <= ST_ACT;
        end
        ST_ACT: begin
          last_q    <= 1'b1;
          use_ram_q <= 1'b0;
          if (!dev_ok_q) begin
            status_q <= STATUS_UNKNOWN;
            state_q  <= ST_EMIT;
          end else if (func_q == FUNC_WRITE) begin
            // The point goes to the slot after the newest; past the limit the
            // oldest point is dropped instead of growing the count.
            present_q[dev_q] <= 1'b1;
            if (over_limit) begin
              head_q[dev_q] <= head_next;
            end else begin
              cnt_q[dev_q] <= cur_cnt_q + CNT_W'(1);
            end
            status_q <= STATUS_OK;
            state_q  <= ST_EMIT;
          end else if (!cur_present_q) begin
            status_q <= STATUS_UNKNOWN;
            state_q  <= ST_EMIT;
          end else if (func_q == FUNC_NEWEST) begin
            if (n_new == '0) begin
              status_q <= STATUS_NONE;
              state_q  <= ST_EMIT;
            end else begin
              n_q     <= n_new;
              idx_q   <= '0;
              state_q <= ST_FETCH;
            end
          end else begin
            first_q <= '0;
            len_q   <= cur_cnt_q;
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (len_q == '0) begin
            state_q <= ST_PICK;
          end else begin
            state_q <= ST_SCMP;
          end
        end
        ST_SCMP: begin
          // Narrow the window to the half that can hold the lower bound.
          if (ram_lt) begin
            first_q <= mid + CNT_W'(1);
            len_q   <= len_q - half - CNT_W'(1);
          end else begin
            len_q <= half;
          end
          state_q <= ST_SRCH;
        end
        ST_PICK: begin
          last_q <= 1'b1;
          if (func_q == FUNC_AFTER) begin
            if (p_in_range) begin
              status_q  <= STATUS_OK;
              use_ram_q <= 1'b1;
              state_q   <= ST_WAIT;
            end else begin
              status_q  <= STATUS_NONE;
              use_ram_q <= 1'b0;
              state_q   <= ST_EMIT;
            end
          end else if (p_in_range) begin
            state_q <= ST_CHK;
          end else if (p_is_zero) begin
            status_q  <= STATUS_NONE;
            use_ram_q <= 1'b0;
            state_q   <= ST_EMIT;
          end else begin
            status_q  <= STATUS_OK;
            use_ram_q <= 1'b1;
            state_q   <= ST_WAIT;
          end
        end
        ST_CHK: begin
          // Exact match wins; otherwise fall back to the earlier point.
          if (ram_eq) begin
            status_q  <= STATUS_OK;
            use_ram_q <= 1'b1;
            state_q   <= ST_EMIT;
          end else if (p_is_zero) begin
            status_q  <= STATUS_NONE;
            use_ram_q <= 1'b0;
            state_q   <= ST_EMIT;
          end else begin
            status_q  <= STATUS_OK;
            use_ram_q <= 1'b1;
            state_q   <= ST_WAIT;
          end
        end
        ST_FETCH: begin
          status_q  <= STATUS_OK;
          use_ram_q <= 1'b1;
          last_q    <= ((idx_q + N_W'(1)) == n_q);
          state_q   <= ST_WAIT;
        end
        ST_WAIT: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_ready_i) begin
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + N_W'(1);
              state_q <= ST_FETCH;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/timestamp_history_store_top.sv
// Top level of the timestamp history store: configuration register,
// output register, point RAM and request sequencer.
// Depends on tshs_pkg, tshs_ram and tshs_seq.
//
// Usage: request items enter on in_valid_i/in_ready_o as in_item_t, result
// items leave on out_valid_o/out_ready_i as out_item_t, and the history limit
// is written through cfg_valid_i/cfg_ready_o while no request is in flight.
// One request is worked at a time; in_ready_o stays low until its final
// result item (last set) has been moved into the output register.
// Writes, unknown devices and empty newest-k requests read no stored point.
// A lookup before/after runs a binary search of at most
// ceil(log2(count + 1)) steps; newest-k fetches one point per result item.
// Every search step and every fetched point uses the single read port of
// the point RAM and its registered read.
// Each item then passes through the output register. When the receiver
// stalls, the item waits there and the sequencer holds its next item.
// Reset clears all device histories and sets the limit to the full ring; the
// point RAM itself is not cleared, since only written slots are ever read.
module timestamp_history_store_top import tshs_pkg::*; #(
  parameter int unsigned DEVICES = DEVICES_DEF,
  parameter int unsigned DEPTH   = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned ADDR_W = DEV_W + SLOT_W;
  localparam int unsigned WORDS  = 2 ** ADDR_W;

  logic [CFG_W-1:0]    max_entries_q;
  logic                res_valid;
  logic                res_ready;
  out_item_t           res_data;
  logic                out_valid_q;
  out_item_t           out_q;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [2*TIME_W-1:0] ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [2*TIME_W-1:0] ram_rdata;

  // History limit register; always ready for a write.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= '0;
    end else if (cfg_valid_i) begin
      max_entries_q <= cfg_data_i;
    end
  end

  // Output register: takes a new item when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res_data;
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Point store: device time in the upper half, host time in the lower half.
  tshs_ram #(
    .WIDTH (2 * TIME_W),
    .WORDS (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request sequencer.
  tshs_seq #(
    .DEVICES (DEVICES),
    .DEPTH   (DEPTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .max_entries_i (max_entries_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_o    (res_data),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata)
  );

endmodule

### dv/tshs_checker.sv
// Result checker for the timestamp history store: watches the request, result
// and limit channels, predicts every result item and compares them in order.
// Depends on tshs_pkg only.
module tshs_checker import tshs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int unsigned      pending_o,
  output int unsigned      errors_o,
  output int unsigned      checked_o
);

  localparam int unsigned DEVICES    = DEVICES_DEF;
  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned NO_SLOT    = DEPTH;
  localparam int unsigned MAX_PRINTS = 60;
  localparam int unsigned OWED_DEPTH = 256;

  // Shadow copy of the point histories and the history limit.
  logic [TIME_W-1:0] gpu_time_mem  [DEVICES][DEPTH];
  logic [TIME_W-1:0] host_time_mem [DEVICES][DEPTH];
  int unsigned       oldest        [DEVICES];
  int unsigned       fill          [DEVICES];
  bit                written       [DEVICES];
  logic [CFG_W-1:0]  limit_reg;

  // Result items still owed by the block, oldest first, in a circular buffer.
  out_item_t   owed [OWED_DEPTH];
  int unsigned owed_wr    = 0;
  int unsigned owed_rd    = 0;
  out_item_t   due;
  int unsigned mismatches = 0;
  int unsigned compared   = 0;

  assign errors_o  = mismatches;
  assign checked_o = compared;

  // Physical slot of the i-th oldest point of a device.
  function automatic int unsigned ring_slot(input int unsigned d, input int unsigned i);
    return (oldest[d] + i) % DEPTH;
  endfunction

  // Binary search: first position, oldest first, whose device time is not below t.
  function automatic int unsigned first_not_below(input int unsigned d,
                                                  input logic [TIME_W-1:0] t);
    int unsigned lo, len, half, mid;
    lo  = 0;
    len = fill[d];
    while (len > 0) begin
      half = len / 2;
      mid  = lo + half;
      if (gpu_time_mem[d][ring_slot(d, mid)] < t) begin
        lo  = mid + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    return lo;
  endfunction

  // Appends one expected result item to the owed list.
  task automatic owe(input out_item_t r);
    owed[owed_wr % OWED_DEPTH] = r;
    owed_wr++;
  endtask

  // Prints one line per mismatch (up to a cap, to bound the log) and counts it.
  task automatic report(input string what, input logic [TIME_W-1:0] got,
                        input logic [TIME_W-1:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] result %0d: %s is %h, expected %h", $time, compared, what, got, want);
    end
    mismatches++;
  endtask

  // Applies one accepted request to the shadow state and queues its results.
  task automatic derive_results(input in_item_t req);
    int unsigned d, lim, n, p, s;
    out_item_t   r;
    d      = req.gpu_index;
    r      = '0;
    r.last = 1'b1;
    if (req.func == FUNC_WRITE) begin
      s = ring_slot(d, fill[d]);
      gpu_time_mem[d][s]  = req.gpu_time;
      host_time_mem[d][s] = req.host_time;
      written[d] = 1'b1;
      lim = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
      // Past the limit only the single oldest point goes, so a lowered limit
      // never shrinks the count.
      if (fill[d] + 1 > lim) begin
        oldest[d] = (oldest[d] + 1) % DEPTH;
      end else begin
        fill[d]++;
      end
      r.status = STATUS_OK;
      owe(r);
    end else if (!written[d]) begin
      r.status = STATUS_UNKNOWN;
      owe(r);
    end else if (req.func == FUNC_NEWEST) begin
      n = req.count_k;
      if (n > fill[d]) n = fill[d];
      if (n > OUT_MAX) n = OUT_MAX;
      if (n == 0) begin
        r.status = STATUS_NONE;
        owe(r);
      end
      // The newest n points, oldest of them first; last marks the final one.
      for (int i = 0; i < n; i++) begin
        s = ring_slot(d, fill[d] - n + i);
        r.status          = STATUS_OK;
        r.found_gpu_time  = gpu_time_mem[d][s];
        r.found_host_time = host_time_mem[d][s];
        r.last            = (i + 1 == n);
        owe(r);
      end
    end else begin
      p = first_not_below(d, req.gpu_time);
      if (req.func == FUNC_BEFORE) begin
        // Exact match first, otherwise the nearest earlier point.
        if (p < fill[d] && gpu_time_mem[d][ring_slot(d, p)] == req.gpu_time) begin
          s = ring_slot(d, p);
        end else if (p == 0) begin
          s = NO_SLOT;
        end else begin
          s = ring_slot(d, p - 1);
        end
      end else begin
        s = (p < fill[d]) ? ring_slot(d, p) : NO_SLOT;
      end
      if (s == NO_SLOT) begin
        r.status = STATUS_NONE;
      end else begin
        r.status          = STATUS_OK;
        r.found_gpu_time  = gpu_time_mem[d][s];
        r.found_host_time = host_time_mem[d][s];
      end
      owe(r);
    end
  endtask

  // Channel monitor: limit writes, then requests, then result comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < DEVICES; d++) begin
        oldest[d]  = 0;
        fill[d]    = 0;
        written[d] = 1'b0;
      end
      limit_reg = '0;
      owed_wr   = 0;
      owed_rd   = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_reg = cfg_data_i;
      if (in_valid_i && in_ready_i) derive_results(in_data_i);
      if (out_valid_i && out_ready_i) begin
        compared++;
        if (owed_wr == owed_rd) begin
          report("status of an unrequested item", out_data_i.status, '0);
        end else begin
          due = owed[owed_rd % OWED_DEPTH];
          owed_rd++;
          if (out_data_i.status !== due.status) begin
            report("status", out_data_i.status, due.status);
          end
          if (out_data_i.found_gpu_time !== due.found_gpu_time) begin
            report("found_gpu_time", out_data_i.found_gpu_time, due.found_gpu_time);
          end
          if (out_data_i.found_host_time !== due.found_host_time) begin
            report("found_host_time", out_data_i.found_host_time, due.found_host_time);
          end
          if (out_data_i.last !== due.last) begin
            report("last", out_data_i.last, due.last);
          end
        end
      end
      pending_o <= owed_wr - owed_rd;
    end
  end

endmodule

### dv/testbench.sv
// Testbench top for the timestamp history store: clock, reset, request and
// limit stimulus, result-side stalls and the final verdict.
// Depends on tshs_pkg, timestamp_history_store_top and tshs_checker.
module testbench;
  import tshs_pkg::*;

  localparam int unsigned PERIOD         = 8;
  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 150;
  localparam int unsigned PHASE_ITEMS    = 30;
  localparam int unsigned FILL_ITEMS     = 36;
  localparam int unsigned LOG_DEPTH      = DEPTH_DEF;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  int unsigned      pending, errors, checked;

  // Stimulus bookkeeping: recent device times per device and run totals.
  logic [TIME_W-1:0] logged  [DEVICES_DEF][LOG_DEPTH];
  logic [TIME_W-1:0] latest  [DEVICES_DEF];
  int unsigned       logged_n [DEVICES_DEF];
  int unsigned       dev_span = 6;
  bit                no_gaps  = 1'b0;
  int unsigned       n_sent = 0, n_writes = 0, n_lookups = 0, n_newest = 0;
  int unsigned       limits_written = 0;

  // Receiver state: stalls, stall-free stretches and the one long hold-off.
  bit          hold_req  = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0, stall_left = 0, free_left = 0;
  int unsigned ready_roll;

  timestamp_history_store_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  tshs_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors),
    .checked_o   (checked)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Run limit in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result-side ready: short and long stalls, free stretches, one long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (free_left != 0) begin
      free_left--;
      out_ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 15) begin
        free_left = $urandom_range(20, 80);
        out_ready <= 1'b1;
      end else if (ready_roll < 65) begin
        out_ready <= 1'b1;
      end else if (ready_roll < 95) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(9, 24);
        out_ready <= 1'b0;
      end
    end
  end

  // Idle cycles before the next request: mostly none or a few, rarely many.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t request(input logic [FUNC_W-1:0] func, input int unsigned dev,
                                       input logic [TIME_W-1:0] gpu_t,
                                       input logic [TIME_W-1:0] host_t,
                                       input logic [K_W-1:0] k);
    in_item_t r;
    r.func      = func;
    r.gpu_index = GPU_IDX_W'(dev);
    r.gpu_time  = gpu_t;
    r.host_time = host_t;
    r.count_k   = k;
    return r;
  endfunction

  // Records a request, then offers it until the block accepts it. Valid stays
  // high between back-to-back items.
  task automatic issue(input in_item_t req);
    int unsigned d, gap;
    d = req.gpu_index;
    if (req.func == FUNC_WRITE) begin
      logged[d][logged_n[d] % LOG_DEPTH] = req.gpu_time;
      logged_n[d]++;
      latest[d] = req.gpu_time;
      n_writes++;
    end else if (req.func == FUNC_NEWEST) begin
      n_newest++;
    end else begin
      n_lookups++;
    end
    n_sent++;
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Random request, mostly aimed at one device with ascending writes and
  // lookups near stored times; the rest goes anywhere with arbitrary times.
  task automatic issue_random(input int unsigned focus);
    in_item_t    req;
    int unsigned d, roll, span;
    roll = $urandom_range(0, 99);
    d = (roll < 60) ? focus : $urandom_range(0, dev_span);
    req.gpu_index = GPU_IDX_W'(d);
    req.host_time = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 70) req.count_k = K_W'($urandom_range(0, 6));
    else if (roll < 90) req.count_k = K_W'($urandom_range(7, 32));
    else req.count_k = K_W'($urandom_range(33, 63));
    roll = $urandom_range(0, 99);
    if (roll < 45) req.func = FUNC_WRITE;
    else if (roll < 63) req.func = FUNC_BEFORE;
    else if (roll < 81) req.func = FUNC_AFTER;
    else req.func = FUNC_NEWEST;
    roll = $urandom_range(0, 99);
    span = (logged_n[d] < LOG_DEPTH) ? logged_n[d] : LOG_DEPTH;
    if (req.func == FUNC_WRITE) begin
      if (roll < 85) req.gpu_time = latest[d] + $urandom_range(1, 2000);
      else if (roll < 95) req.gpu_time = {$urandom, $urandom};
      else req.gpu_time = latest[d];
    end else if (roll < 40 && span != 0) begin
      req.gpu_time = logged[d][$urandom_range(0, span - 1)];
    end else if (roll < 48 && span != 0) begin
      req.gpu_time = logged[d][$urandom_range(0, span - 1)] + 1;
    end else if (roll < 55 && span != 0) begin
      req.gpu_time = logged[d][$urandom_range(0, span - 1)] - 1;
    end else if (roll < 65) begin
      req.gpu_time = latest[d] + $urandom_range(1, 3000);
    end else if (roll < 75) begin
      req.gpu_time = latest[d] - $urandom_range(0, 5000);
    end else if (roll < 85) begin
      req.gpu_time = {$urandom, $urandom};
    end else if (roll < 92) begin
      req.gpu_time = '0;
    end else begin
      req.gpu_time = '1;
    end
    issue(req);
  endtask

  // Waits until every result owed so far has been taken.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Writes the history limit once the block has gone idle.
  task automatic write_limit(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limits_written++;
  endtask

  // Main sequence: reset, directed cases, then random phases per limit.
  initial begin
    for (int d = 0; d < DEVICES_DEF; d++) begin
      logged_n[d] = 0;
      latest[d]   = {16'h0, $urandom, 16'h0};
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lookups on devices that were never written.
    issue(request(FUNC_NEWEST, 7, 0, 0, 5));
    issue(request(FUNC_BEFORE, 3, 64'd10, '1, 0));
    issue(request(FUNC_AFTER, 3, '1, 0, '1));
    // Device 0 gets points at both ends of the time range.
    issue(request(FUNC_WRITE, 0, '0, '1, 0));
    issue(request(FUNC_WRITE, 0, 64'd100, '0, '1));
    issue(request(FUNC_WRITE, 0, 64'd200, 64'h0123_4567_89AB_CDEF, 0));
    issue(request(FUNC_WRITE, 0, '1, 64'hFEDC_BA98_7654_3210, 0));
    // Exact matches, nearest earlier and first later points.
    issue(request(FUNC_BEFORE, 0, '0, 0, 0));
    issue(request(FUNC_BEFORE, 0, 64'd150, 0, 0));
    issue(request(FUNC_BEFORE, 0, '1, 0, 0));
    issue(request(FUNC_AFTER, 0, 64'd150, 0, 0));
    issue(request(FUNC_AFTER, 0, '0, 0, 0));
    issue(request(FUNC_AFTER, 0, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0));
    // Device 1 starts late, so nothing lies before or after its only point.
    issue(request(FUNC_WRITE, 1, 64'd1000, 64'd7, 0));
    issue(request(FUNC_BEFORE, 1, 64'd999, 0, 0));
    issue(request(FUNC_AFTER, 1, 64'd1001, 0, 0));
    // Newest-k asking for none, a few and more than are stored.
    issue(request(FUNC_NEWEST, 0, 0, 0, 0));
    issue(request(FUNC_NEWEST, 0, 0, 0, 2));
    issue(request(FUNC_NEWEST, 0, 0, 0, '1));
    // An out-of-order point leaves device 1 unsorted.
    issue(request(FUNC_WRITE, 1, 64'd500, 64'd9, 0));
    issue(request(FUNC_BEFORE, 1, 64'd700, 0, 0));
    issue(request(FUNC_AFTER, 1, 64'd600, 0, 0));
    repeat (PHASE_ITEMS) issue_random(0);

    // Full ring: device 2 is written back to back past its capacity.
    write_limit(6'd32);
    no_gaps = 1'b1;
    repeat (FILL_ITEMS) begin
      issue(request(FUNC_WRITE, 2, latest[2] + $urandom_range(1, 500), {$urandom, $urandom},
                    K_W'($urandom_range(0, 63))));
    end
    no_gaps = 1'b0;
    issue(request(FUNC_NEWEST, 2, 0, 0, 6'd32));
    repeat (20) issue_random(2);

    // Limit lowered below the stored count of device 2.
    write_limit(6'd3);
    repeat (PHASE_ITEMS) issue_random(2);
    write_limit(6'd1);
    repeat (PHASE_ITEMS) issue_random(4);
    // Values above the ring size act as the full ring.
    write_limit(6'd63);
    repeat (PHASE_ITEMS) issue_random(3);
    write_limit(6'd0);
    repeat (PHASE_ITEMS) issue_random(5);
    // The receiver holds off long enough for the block to stall its input.
    write_limit(6'd40);
    hold_req <= 1'b1;
    repeat (PHASE_ITEMS) issue_random(1);
    dev_span = 7;
    write_limit(CFG_W'($urandom_range(1, 31)));
    repeat (PHASE_ITEMS) issue_random(7);

    // Drain, then watch for stray results.
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d writes, %0d lookups, %0d newest-k) under %0d limits.",
             n_sent, n_writes, n_lookups, n_newest, limits_written + 1);
    $display("%0d result items compared, %0d mismatches, one long result-side hold-off.",
             checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/tshs_pkg.sv
design/tshs_ram.sv
design/tshs_seq.sv
design/timestamp_history_store_top.sv
dv/tshs_checker.sv
dv/testbench.sv
